// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL, used by the group FIFO.
// Simulation builds get the checks. Synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever a holds, c must hold too.
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("implication check failed");

// Next-cycle implication: whenever a holds, c must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)

`endif

`endif

// ----- rtl/core/c2p_pkg.sv -----
`default_nettype none

package c2p_pkg;

    localparam int GROUP_PIXELS_DEF = 16;
    localparam int MAX_PLANES_DEF   = 8;
    localparam int PLANES_LIMIT     = 8;
    localparam int WORD_W           = 16;
    localparam int LIDX_W           = 3;
    localparam int GQ_DEPTH         = 2;

    localparam logic       OP_PIXEL       = 1'b0;
    localparam logic       OP_REMAP_WRITE = 1'b1;

    localparam logic       CFG_PLANE_COUNT  = 1'b0;
    localparam logic       CFG_REMAP_ENABLE = 1'b1;

    localparam logic [3:0] PLANE_COUNT_RESET  = 4'd8;
    localparam logic       REMAP_ENABLE_RESET = 1'b0;

    typedef struct packed {
        logic       op;
        logic [7:0] pixel_value;
        logic [7:0] remap_index;
        logic [7:0] remap_value;
    } c2p_in_t;

    typedef struct packed {
        logic [15:0] plane_word;
        logic [2:0]  plane_number;
        logic        last_plane;
    } c2p_out_t;

    // Status of the group queue as seen by the front and the back.
    typedef struct packed {
        logic full;
        logic one_left;
        logic not_empty;
    } c2p_qstat_t;

    // Planes in use for a plane count; zero when the count is not supported.
    function automatic logic [PLANES_LIMIT-1:0] plane_mask(input logic [3:0] n,
                                                           input int max_planes);
        logic [PLANES_LIMIT-1:0] m;
        m = '0;
        if ((n == 4'd1) && (max_planes >= 1)) m = 8'h01;
        if ((n == 4'd2) && (max_planes >= 2)) m = 8'h03;
        if ((n == 4'd4) && (max_planes >= 4)) m = 8'h0F;
        if ((n == 4'd8) && (max_planes >= 8)) m = 8'hFF;
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/chunky_to_planar_converter.sv -----
// Channel   Handshake            Payload
// input     push / full          item   (c2p_in_t: op, pixel_value, remap_index, remap_value)
// result    pop / empty          result (c2p_out_t: plane_word, plane_number, last_plane)
// config    cfg_valid/cfg_ready  cfg_index, cfg_data (cfg_ready is always high)
//
// One input item is taken every cycle while full is low; a group's plane words leave one
// per cycle while the receiver keeps popping. A group's last pixel is registered in the
// first stage, and the finished group then passes the queue and the output register.
// Input stalls while the two-entry group queue is full, or while it has one slot left
// and a finished group waits in the first stage.
// Reset clears the position, accumulators, queue and registers; the remap table is not cleared.
`default_nettype none

module chunky_to_planar_converter #(
    parameter int GROUP_PIXELS = c2p_pkg::GROUP_PIXELS_DEF,
    parameter int MAX_PLANES   = c2p_pkg::MAX_PLANES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire c2p_pkg::c2p_in_t   item,
    output logic                    full,
    output logic                    empty,
    input  wire logic               pop,
    output c2p_pkg::c2p_out_t       result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [3:0]         cfg_data
);

    localparam int DW = MAX_PLANES * c2p_pkg::WORD_W + c2p_pkg::LIDX_W;

    logic [3:0]          plane_count_reg;
    logic                remap_enable_reg;
    logic                gq_push;
    logic                gq_pop;
    logic [DW-1:0]       gq_data;
    logic [DW-1:0]       gq_head;
    c2p_pkg::c2p_qstat_t qstat;

    // Configuration writes are always accepted in the cycle they are offered.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_count_reg  <= c2p_pkg::PLANE_COUNT_RESET;
            remap_enable_reg <= c2p_pkg::REMAP_ENABLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                c2p_pkg::CFG_PLANE_COUNT:  plane_count_reg  <= cfg_data;
                c2p_pkg::CFG_REMAP_ENABLE: remap_enable_reg <= cfg_data[0];
                default:                   plane_count_reg  <= plane_count_reg;
            endcase
        end
    end

    // The front takes every transfer, updates the remap table, and builds the
    // plane accumulators. A finished group goes into the queue as one record.
    c2p_front #(
        .GROUP_PIXELS (GROUP_PIXELS),
        .MAX_PLANES   (MAX_PLANES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .item         (item),
        .full         (full),
        .plane_count  (plane_count_reg),
        .remap_enable (remap_enable_reg),
        .qstat        (qstat),
        .gq_push      (gq_push),
        .gq_data      (gq_data)
    );

    c2p_group_fifo #(
        .DW (DW)
    ) u_group_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (gq_push),
        .push_data (gq_data),
        .pop       (gq_pop),
        .head_data (gq_head),
        .qstat     (qstat)
    );

    // The back walks the planes of the oldest group into the output register.
    c2p_back #(
        .MAX_PLANES (MAX_PLANES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .head_data (gq_head),
        .gq_pop    (gq_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire

// ----- rtl/core/c2p_front.sv -----
`default_nettype none

module c2p_front #(
    parameter int GROUP_PIXELS = c2p_pkg::GROUP_PIXELS_DEF,
    parameter int MAX_PLANES   = c2p_pkg::MAX_PLANES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire c2p_pkg::c2p_in_t     item,
    output logic                      full,
    input  wire logic [3:0]           plane_count,
    input  wire logic                 remap_enable,
    input  wire c2p_pkg::c2p_qstat_t  qstat,
    output logic                      gq_push,
    output logic [MAX_PLANES*c2p_pkg::WORD_W+c2p_pkg::LIDX_W-1:0] gq_data
);

    localparam int PW = $clog2(GROUP_PIXELS);
    localparam int WW = c2p_pkg::WORD_W;

    logic [7:0]                         remap_mem [256];
    logic [7:0]                         remap_q;
    logic [c2p_pkg::PLANES_LIMIT-1:0]   pmask_cfg;
    logic                               accept;
    logic                               pix_ok;
    logic                               pos_last;

    logic [PW-1:0]                      pos_reg, pos_next;
    logic                               s1_valid_reg;
    logic                               s1_last_reg;
    logic [PW-1:0]                      s1_pos_reg;
    logic [7:0]                         s1_raw_reg;
    logic                               s1_remap_reg;
    logic [c2p_pkg::PLANES_LIMIT-1:0]   s1_pmask_reg;
    logic [c2p_pkg::LIDX_W-1:0]         s1_lidx_reg;

    logic [WW-1:0]                      acc_reg [MAX_PLANES];
    logic [WW-1:0]                      acc_upd [MAX_PLANES];
    logic [7:0]                         pix;
    logic [WW-1:0]                      bit_mask;

    assign pmask_cfg = c2p_pkg::plane_mask(plane_count, MAX_PLANES);

    // A finished group in the first stage needs a queue slot at the next edge.
    assign full     = qstat.full | (s1_valid_reg & s1_last_reg & qstat.one_left);
    assign accept   = push & ~full;
    assign pix_ok   = accept & (item.op == c2p_pkg::OP_PIXEL) & (|pmask_cfg);
    assign pos_last = (pos_reg == PW'(GROUP_PIXELS - 1));
    assign pos_next = pos_last ? '0 : pos_reg + PW'(1);

    always_ff @(posedge clk)
    begin
        if (accept && (item.op == c2p_pkg::OP_REMAP_WRITE))
        begin
            remap_mem[item.remap_index] <= item.remap_value;
        end
        if (pix_ok)
        begin
            remap_q <= remap_mem[item.pixel_value];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pix_ok;
            if (pix_ok)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_ok)
        begin
            s1_last_reg  <= pos_last;
            s1_pos_reg   <= pos_reg;
            s1_raw_reg   <= item.pixel_value;
            s1_remap_reg <= remap_enable;
            s1_pmask_reg <= pmask_cfg;
            s1_lidx_reg  <= c2p_pkg::LIDX_W'(plane_count - 4'd1);
        end
    end

    assign pix = s1_remap_reg ? remap_q : s1_raw_reg;

    // Places beyond the word width leave the word untouched.
    always_comb
    begin
        for (int k = 0; k < WW; k++)
        begin
            bit_mask[WW-1-k] = (6'(s1_pos_reg) == 6'(k));
        end
    end

    always_comb
    begin
        for (int b = 0; b < MAX_PLANES; b++)
        begin
            acc_upd[b] = acc_reg[b] | (bit_mask & {WW{pix[b] & s1_pmask_reg[b]}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < MAX_PLANES; b++)
            begin
                acc_reg[b] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            for (int b = 0; b < MAX_PLANES; b++)
            begin
                acc_reg[b] <= s1_last_reg ? '0 : acc_upd[b];
            end
        end
    end

    assign gq_push = s1_valid_reg & s1_last_reg;

    always_comb
    begin
        gq_data = '0;
        gq_data[MAX_PLANES*WW +: c2p_pkg::LIDX_W] = s1_lidx_reg;
        for (int b = 0; b < MAX_PLANES; b++)
        begin
            gq_data[b*WW +: WW] = acc_upd[b];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/c2p_group_fifo.sv -----
`default_nettype none

`include "assert_macros.svh"

module c2p_group_fifo #(
    parameter int DW = c2p_pkg::MAX_PLANES_DEF * c2p_pkg::WORD_W + c2p_pkg::LIDX_W
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic [DW-1:0]        push_data,
    input  wire logic                 pop,
    output logic [DW-1:0]             head_data,
    output c2p_pkg::c2p_qstat_t       qstat
);

    localparam int DEPTH = c2p_pkg::GQ_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [DW-1:0] data_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (AW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

    assign head_data       = data_reg[rd_ptr_reg];
    assign qstat.full      = (count_reg == (AW+1)'(DEPTH));
    assign qstat.one_left  = (count_reg == (AW+1)'(DEPTH - 1));
    assign qstat.not_empty = (count_reg != '0);

    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, count_reg != (AW+1)'(DEPTH))
    `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, count_reg != '0)
    `ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + (AW+1)'(1))

endmodule

`default_nettype wire

// ----- rtl/core/c2p_back.sv -----
`default_nettype none

module c2p_back #(
    parameter int MAX_PLANES = c2p_pkg::MAX_PLANES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire c2p_pkg::c2p_qstat_t  qstat,
    input  wire logic [MAX_PLANES*c2p_pkg::WORD_W+c2p_pkg::LIDX_W-1:0] head_data,
    output logic                      gq_pop,
    output c2p_pkg::c2p_out_t         result,
    output logic                      empty,
    input  wire logic                 pop
);

    localparam int WW    = c2p_pkg::WORD_W;
    localparam int LW    = c2p_pkg::LIDX_W;
    localparam int ALL_W = c2p_pkg::PLANES_LIMIT * WW;

    logic [ALL_W-1:0] words_all;
    logic [LW-1:0]    last_idx;
    logic [LW-1:0]    idx_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             at_last;
    c2p_pkg::c2p_out_t out_reg;

    assign words_all = ALL_W'(head_data[MAX_PLANES*WW-1:0]);
    assign last_idx  = head_data[MAX_PLANES*WW +: LW];
    assign advance   = qstat.not_empty & (~out_valid_reg | pop);
    assign at_last   = (idx_reg == last_idx);
    assign gq_pop    = advance & at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                idx_reg       <= at_last ? '0 : idx_reg + LW'(1);
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.plane_word   <= words_all[idx_reg*WW +: WW];
            out_reg.plane_number <= idx_reg;
            out_reg.last_plane   <= at_last;
        end
    end

    assign result = out_reg;
    assign empty  = ~out_valid_reg;

endmodule

`default_nettype wire

// ----- sim/c2p_tb_pkg.sv -----
`timescale 1ns / 100ps

package c2p_tb_pkg;

    // Tracks the converter's state and holds the plane words it must produce.
    class plane_word_tracker;

        logic [15:0]       accum [8];
        int unsigned       position;
        logic [7:0]        palette [256];
        logic [3:0]        plane_count;
        logic              remap_on;
        c2p_pkg::c2p_out_t pending_words [$];
        int                failures;

        function new();
            foreach (accum[i])
                accum[i] = '0;
            foreach (palette[i])
                palette[i] = '0;
            position    = 0;
            plane_count = c2p_pkg::PLANE_COUNT_RESET;
            remap_on    = c2p_pkg::REMAP_ENABLE_RESET;
            failures    = 0;
        endfunction

        // Only 1, 2, 4 and 8 planes are supported; anything else yields zero.
        function int planes_in_use();
            case (plane_count)
                4'd1, 4'd2, 4'd4, 4'd8: return int'(plane_count);
                default:                return 0;
            endcase
        endfunction

        function void write_register(input logic idx, input logic [3:0] data);
            if (idx == c2p_pkg::CFG_PLANE_COUNT)
                plane_count = data;
            else
                remap_on = data[0];
        endfunction

        function void note_transfer(input c2p_pkg::c2p_in_t it);
            int                n;
            logic [7:0]        color;
            c2p_pkg::c2p_out_t w;
            if (it.op == c2p_pkg::OP_REMAP_WRITE)
            begin
                palette[it.remap_index] = it.remap_value;
                return;
            end
            n = planes_in_use();
            if (n == 0)
                return;
            color = remap_on ? palette[it.pixel_value] : it.pixel_value;
            for (int b = 0; b < n; b++)
            begin
                if (color[b] && position < 16)
                    accum[b] = accum[b] | (16'h8000 >> position);
            end
            position++;
            if (position < c2p_pkg::GROUP_PIXELS_DEF)
                return;
            for (int b = 0; b < n; b++)
            begin
                w.plane_word   = accum[b];
                w.plane_number = 3'(b);
                w.last_plane   = (b == n - 1);
                pending_words.push_back(w);
            end
            foreach (accum[i])
                accum[i] = '0;
            position = 0;
        endfunction

        task report_mismatch(input string what, input int unsigned got,
                             input int unsigned want);
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
            failures++;
        endtask

        task check_word(input c2p_pkg::c2p_out_t r);
            c2p_pkg::c2p_out_t w;
            if (pending_words.size() == 0)
            begin
                report_mismatch("plane word with nothing expected", 32'(r.plane_word), 0);
                return;
            end
            w = pending_words.pop_front();
            if (r.plane_word !== w.plane_word)
                report_mismatch("plane_word", 32'(r.plane_word), 32'(w.plane_word));
            if (r.plane_number !== w.plane_number)
                report_mismatch("plane_number", 32'(r.plane_number), 32'(w.plane_number));
            if (r.last_plane !== w.last_plane)
                report_mismatch("last_plane", 32'(r.last_plane), 32'(w.last_plane));
        endtask

    endclass

endpackage

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    // The run is short; this bound is far beyond the slowest legal run.
    localparam int CYCLE_LIMIT   = 100000;
    // A pixel passes the first stage, the group queue and the output register on its way to the result ports.
    localparam int SETTLE_CYCLES = 8;
    // Length of the long receiver hold-off used to back up the group queue.
    localparam int HOLD_CYCLES   = 300;
    localparam int SEGMENTS      = 6;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              push      = 1'b0;
    c2p_pkg::c2p_in_t  item      = '0;
    logic              full;
    logic              empty;
    logic              pop       = 1'b0;
    c2p_pkg::c2p_out_t result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = 1'b0;
    logic [3:0]        cfg_data  = '0;

    c2p_tb_pkg::plane_word_tracker tracker;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count    = 0;

    // The main flow flips hold_toggle; the receiver notices and holds off.
    logic        hold_toggle = 1'b0;
    logic        hold_seen   = 1'b0;
    int unsigned hold_left   = 0;

    // Remap entries already written, so that enabled remapping never reads
    // an entry that holds no defined value yet.
    bit          palette_written [256];
    logic [7:0]  written_entries [$];

    chunky_to_planar_converter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a missing plane word ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side. Values are sampled at the edge before any update lands, so
    // a transfer is exactly a cycle where pop was high and empty was low. The
    // next value of pop comes from the stall rate, or stays low during a
    // requested hold-off that this process counts down itself.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                tracker.check_word(result);
            if (hold_toggle != hold_seen)
            begin
                hold_seen <= hold_toggle;
                hold_left <= HOLD_CYCLES;
                pop       <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                pop       <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Picks the idling pattern of both sides for one stretch of the run.
    task automatic set_idling(input int phase);
        case (phase)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 68;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 68;
            end
            default:
            begin
                send_idle_pct  = 19;
                recv_stall_pct = 19;
            end
        endcase
    endtask

    // Offers one item and returns at the edge where it is transferred. push is
    // left high so that back-to-back items need no gap.
    task automatic send_item(input c2p_pkg::c2p_in_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tracker.note_transfer(it);
        if (it.op == c2p_pkg::OP_REMAP_WRITE && !palette_written[it.remap_index])
        begin
            palette_written[it.remap_index] = 1'b1;
            written_entries.push_back(it.remap_index);
        end
    endtask

    // The fields a pixel does not use carry random noise.
    task automatic send_pixel(input logic [7:0] px);
        c2p_pkg::c2p_in_t it;
        it.op          = c2p_pkg::OP_PIXEL;
        it.pixel_value = px;
        it.remap_index = 8'($urandom);
        it.remap_value = 8'($urandom);
        send_item(it);
    endtask

    task automatic send_remap(input logic [7:0] idx, input logic [7:0] val);
        c2p_pkg::c2p_in_t it;
        it.op          = c2p_pkg::OP_REMAP_WRITE;
        it.pixel_value = 8'($urandom);
        it.remap_index = idx;
        it.remap_value = val;
        send_item(it);
    endtask

    // With remapping on, only entries written earlier may be looked up.
    function automatic logic [7:0] pick_pixel();
        if (tracker.remap_on && written_entries.size() > 0)
            return written_entries[$urandom_range(written_entries.size() - 1)];
        return 8'($urandom_range(255));
    endfunction

    // Stops offering items, waits for every expected plane word to be
    // transferred, and then lets the pipeline settle so that discarded
    // pixels and table writes are done too.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (tracker.pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [3:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.write_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int          seg_planes [SEGMENTS];
        logic [3:0]  seg_remap  [SEGMENTS];
        logic [7:0]  group_pixels [16];
        int          count;

        seg_planes   = '{4, 0, 1, 8, 15, 2};
        seg_remap    = '{4'h1, 4'hE, 4'h1, 4'h0, 4'hF, 4'h0};
        group_pixels = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h02, 8'h40, 8'h04, 8'h20,
                         8'h08, 8'h10, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'hFE, 8'h7F};

        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Table writes at both ends of the index range come
        // first; they must leave the group position alone.
        set_idling(0);
        send_remap(8'h00, 8'hFF);
        send_remap(8'hFF, 8'h00);
        send_remap(8'h80, 8'h01);
        send_remap(8'h01, 8'h80);

        // One full group of raw pixels in the default eight-plane mode, with
        // walking ones and both extreme values among its pixels.
        foreach (group_pixels[i])
            send_pixel(group_pixels[i]);
        wait_idle();

        // An unsupported plane count drops pixels without moving the group.
        write_register(c2p_pkg::CFG_PLANE_COUNT, 4'd3);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        wait_idle();

        // Start a remapped group in two-plane mode and leave it unfinished, so
        // the first random stretch changes the plane count in mid-group.
        write_register(c2p_pkg::CFG_PLANE_COUNT, 4'd2);
        write_register(c2p_pkg::CFG_REMAP_ENABLE, 4'd1);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h80);

        // Random part: each stretch has its own register settings and idling.
        // Groups run across the stretch boundaries on purpose.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_idle();
            write_register(c2p_pkg::CFG_PLANE_COUNT, 4'(seg_planes[seg]));
            write_register(c2p_pkg::CFG_REMAP_ENABLE, seg_remap[seg]);
            set_idling(seg % 4);
            count = $urandom_range(6, 8);
            for (int i = 0; i < count; i++)
            begin
                if ($urandom_range(99) < 15)
                    send_remap(8'($urandom), 8'($urandom));
                else
                    send_pixel(pick_pixel());
            end
        end

        // Back-pressure: the receiver holds off for a long stretch while the
        // sender keeps offering eight-plane pixels, so that two finished groups
        // pile up in the queue and full has to stall the input.
        wait_idle();
        write_register(c2p_pkg::CFG_PLANE_COUNT, 4'd8);
        write_register(c2p_pkg::CFG_REMAP_ENABLE, 4'd0);
        set_idling(0);
        hold_toggle <= ~hold_toggle;
        for (int i = 0; i < 36; i++)
            send_pixel(pick_pixel());

        // Last stretch with both sides idling, then drain.
        set_idling(3);
        for (int i = 0; i < 8; i++)
            send_pixel(pick_pixel());
        wait_idle();

        if (tracker.pending_words.size() != 0)
            tracker.report_mismatch("plane words never transferred",
                                    tracker.pending_words.size(), 0);

        if (tracker.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/c2p_pkg.sv
rtl/core/c2p_front.sv
rtl/core/c2p_group_fifo.sv
rtl/core/c2p_back.sv
rtl/core/chunky_to_planar_converter.sv
sim/c2p_tb_pkg.sv
sim/tb_top.sv
